/* hdl/assert_macros.svh */
// Assertion macros shared by the checker modules of the particle pair block.
// Each macro expects a signal named clk where it is used; PPP_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ppp_pkg.sv */
// Shared types and constants of the particle pair block.
// No dependencies; the store, compare and top-level files import this package.
`default_nettype none

package ppp_pkg;

  localparam int COORD_W    = 16;  // Q8.8 position and mass width
  localparam int IDX_W      = 6;   // width of the index fields of a result
  localparam int SQ_W       = 32;  // square of one coordinate difference
  localparam int RAD_W      = 17;  // twice the mass
  localparam int DIST_W     = 34;  // sum of three squares, square of the radius
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t mass;
  } particle_t;

  // A pipeline slot or a pending pair: valid flag and earlier particle index.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } tag_t;

endpackage

`default_nettype wire

/* hdl/ppp_store.sv */
// Particle memory of the pair block: one write port, one registered read port.
// Depends on ppp_pkg for the particle record type.
`default_nettype none

module ppp_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire ppp_pkg::particle_t wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output ppp_pkg::particle_t      rd_data
);
  import ppp_pkg::*;

  particle_t mem_r [DEPTH];
  particle_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/ppp_cmp.sv */
// Pipelined distance compare unit, shared by all stored particles of a scan.
// Depends on ppp_pkg; takes one stored particle per advancing cycle.
`default_nettype none

module ppp_cmp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire ppp_pkg::tag_t      in_tag,
  input  wire ppp_pkg::particle_t ref_p,
  input  wire ppp_pkg::coord_t    px,
  input  wire ppp_pkg::coord_t    py,
  input  wire ppp_pkg::coord_t    pz,
  output ppp_pkg::tag_t           hit_tag,
  output logic                    busy
);
  import ppp_pkg::*;

  logic [COORD_W:0]   dx, dy, dz;
  logic [COORD_W:0]   adx, ady, adz;
  logic [COORD_W-1:0] adx_r, ady_r, adz_r;
  logic [RAD_W-1:0]   rad_r;
  tag_t               tag2_r, tag3_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0]  rsq_r;
  logic [DIST_W-1:0]  dist_sq;

  // Differences are taken one bit wider; their magnitude always fits 16 bits.
  always_comb begin
    dx  = {px[COORD_W-1], px} - {ref_p.x[COORD_W-1], ref_p.x};
    dy  = {py[COORD_W-1], py} - {ref_p.y[COORD_W-1], ref_p.y};
    dz  = {pz[COORD_W-1], pz} - {ref_p.z[COORD_W-1], ref_p.z};
    adx = dx[COORD_W] ? (~dx + (COORD_W+1)'(1)) : dx;
    ady = dy[COORD_W] ? (~dy + (COORD_W+1)'(1)) : dy;
    adz = dz[COORD_W] ? (~dz + (COORD_W+1)'(1)) : dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (advance) begin
      tag2_r <= in_tag;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      adx_r <= adx[COORD_W-1:0];
      ady_r <= ady[COORD_W-1:0];
      adz_r <= adz[COORD_W-1:0];
      rad_r <= {ref_p.mass, 1'b0};
      sqx_r <= SQ_W'(adx_r) * SQ_W'(adx_r);
      sqy_r <= SQ_W'(ady_r) * SQ_W'(ady_r);
      sqz_r <= SQ_W'(adz_r) * SQ_W'(adz_r);
      rsq_r <= DIST_W'(rad_r) * DIST_W'(rad_r);
    end
  end

  assign dist_sq       = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  assign hit_tag.valid = tag3_r.valid && (dist_sq < rsq_r);
  assign hit_tag.index = tag3_r.index;
  assign busy          = tag2_r.valid || tag3_r.valid;

endmodule

`default_nettype wire

/* hdl/pairwise_proximity_pairs_core.sv */
// Top level of the particle pair block: sequencer, result register and wiring.
// Depends on ppp_pkg, ppp_store and ppp_cmp.
//
// Usage: each input item is one particle. in_tdata carries pos_x, pos_y, pos_z
// and mass; in_tuser[0] is new_frame, which restarts the frame so that this
// particle becomes index 0. The particle is compared with every earlier
// particle of its frame, one stored particle per cycle while out_tready does
// not stall the result register, through the compare pipeline fed from the
// particle memory. Each pair in range leaves as one result item (first_index,
// second_index), with out_tlast on the final pair of each particle.
// Particles beyond MAX_PARTICLES in a frame are dropped without results.
// Flow: while a particle with an index above 0 is scanned, in_tready stays low
// through its memory reads and the drain of the read and compare stages, until
// any last pair is handed over; index 0 and dropped particles leave in_tready
// high. The final pair of a particle is loaded into the result register as
// in_tready rises again. A stall on out_tready freezes the scan and the
// compare pipeline until the result register frees up; nothing is lost.
// Reset empties the frame and the result register; memory is not cleared.
`default_nettype none

module pairwise_proximity_pairs_core #(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], mass [63:48]
  input  wire logic [ppp_pkg::IN_DATA_W-1:0]      in_tdata,
  // new_frame [0]
  input  wire logic [0:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // first_index [5:0], second_index [11:6], zeros [15:12]
  output logic [ppp_pkg::OUT_DATA_W-1:0]          out_tdata,
  // last_pair
  output logic                                    out_tlast
);
  import ppp_pkg::*;

  localparam int ADDR_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   j_r, j_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  coord_t              px_r, py_r, pz_r;
  tag_t                tag1_r;
  tag_t                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_first_r, out_first_nxt;
  logic [IDX_W-1:0]    out_second_r, out_second_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept, store, full;
  logic [CNT_W-1:0]    base_cnt;
  logic                advance, issue, last_issue, flush_go;
  particle_t           in_p, rd_p;
  tag_t                hit_tag;
  logic                cmp_busy;

  assign in_p.x    = in_tdata[15:0];
  assign in_p.y    = in_tdata[31:16];
  assign in_p.z    = in_tdata[47:32];
  assign in_p.mass = in_tdata[63:48];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign base_cnt   = in_tuser[0] ? '0 : count_r;
  assign full       = (base_cnt == CNT_W'(MAX_PARTICLES));
  assign store      = accept && !full;

  // Everything behind the memory moves only when the result register can load.
  assign advance    = !out_valid_r || out_tready;
  assign issue      = (state_r == ST_SCAN) && advance;
  assign last_issue = issue && (rd_addr_r == (j_r - ADDR_W'(1)));
  assign flush_go   = (state_r == ST_FLUSH) && advance && !tag1_r.valid && !cmp_busy;

  ppp_store #(
    .DEPTH  (MAX_PARTICLES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (base_cnt[ADDR_W-1:0]),
    .wr_data (in_p),
    .rd_en   (advance),
    .rd_addr (rd_addr_r),
    .rd_data (rd_p)
  );

  ppp_cmp u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_tag  (tag1_r),
    .ref_p   (rd_p),
    .px      (px_r),
    .py      (py_r),
    .pz      (pz_r),
    .hit_tag (hit_tag),
    .busy    (cmp_busy)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    rd_addr_nxt = rd_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (store) begin
          j_nxt       = base_cnt[ADDR_W-1:0];
          count_nxt   = base_cnt + CNT_W'(1);
          rd_addr_nxt = '0;
          if (base_cnt != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_addr_nxt = rd_addr_r + ADDR_W'(1);
        end
        if (last_issue) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A hit is held back in pend_r, since only the next hit or the end of the
  // scan tells whether it is the last pair of this particle.
  always_comb begin
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_last_nxt   = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
      if (hit_tag.valid) begin
        if (pend_r.valid) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = pend_r.index;
          out_second_nxt = IDX_W'(j_r);
          out_last_nxt   = 1'b0;
        end
        pend_nxt = hit_tag;
      end else if (flush_go && pend_r.valid) begin
        out_valid_nxt  = 1'b1;
        out_first_nxt  = pend_r.index;
        out_second_nxt = IDX_W'(j_r);
        out_last_nxt   = 1'b1;
        pend_nxt.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tag1_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        tag1_r.valid <= issue;
        tag1_r.index <= IDX_W'(rd_addr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    rd_addr_r    <= rd_addr_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_last_r   <= out_last_nxt;
    if (store) begin
      px_r <= in_p.x;
      py_r <= in_p.y;
      pz_r <= in_p.z;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2 * IDX_W)'(0), out_second_r, out_first_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* hdl/ppp_checker.sv */
// Port-level checks of the particle pair block, attached to the top by bind.
// Depends on assert_macros.svh and on the port names of the top level.
`default_nettype none
`include "assert_macros.svh"

module ppp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [0:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic       out_tlast
);

  // A result item that is not taken stays offered.
  `PPP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result item dropped while stalled")

  // Reset leaves the block empty and ready for a particle.
  `PPP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")

  // The first particle of a frame causes no comparison, so the block stays ready.
  `PPP_ASSERT(a_frame_start, in_tvalid && in_tready && in_tuser[0] |=> in_tready, "first particle of a frame started a scan")

  // A pair that is not the last one of its particle only shows while that
  // particle is still being scanned.
  `PPP_ASSERT(a_open_pair, out_tvalid && !out_tlast |-> !in_tready, "unfinished pair list while ready for a new particle")

endmodule

bind pairwise_proximity_pairs_core ppp_checker u_ppp_checker (.*);

`default_nettype wire
